>>> sv/flat_json_field_extractor_assert.svh
// assertion macros used by the extractor's result queue
`ifndef FLAT_JSON_FIELD_EXTRACTOR_ASSERT_SVH
`define FLAT_JSON_FIELD_EXTRACTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FJE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fje assertion failed");

// next-cycle implication, checked out of reset
`define FJE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fje assertion failed");

`endif

>>> sv/fje_pkg.sv
// types and constants of the flat json field extractor
package fje_pkg;

    localparam int KEY_CHARS = 8;
    localparam int KEY_IDX_W = $clog2(KEY_CHARS);
    localparam int KEY_W = 8 * KEY_CHARS;
    localparam int LEN_W = 4;
    localparam int POS_W = 4;
    localparam int ACC_W = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [KEY_W-1:0] NUMBER_KEY_RST = 64'h0000_0000_7472_6F70;
    localparam logic [LEN_W-1:0] NUMBER_LEN_RST = 4'd4;
    localparam logic [KEY_W-1:0] STRING_KEY_RST = 64'h0000_006E_656B_6F74;
    localparam logic [LEN_W-1:0] STRING_LEN_RST = 4'd5;
    localparam logic [POS_W-1:0] POS_MAX = 4'd15;

    // register indexes on the configuration port
    localparam logic [1:0] REG_NUMBER_KEY = 2'd0;
    localparam logic [1:0] REG_NUMBER_LEN = 2'd1;
    localparam logic [1:0] REG_STRING_KEY = 2'd2;
    localparam logic [1:0] REG_STRING_LEN = 2'd3;

    typedef enum logic [3:0] {
        PH_BRACE    = 4'd0,
        PH_KEY_OPEN = 4'd1,
        PH_KEY_NAME = 4'd2,
        PH_COLON    = 4'd3,
        PH_VALUE    = 4'd4,
        PH_NUMBER   = 4'd5,
        PH_STRING   = 4'd6,
        PH_ESCAPE   = 4'd7,
        PH_COMMA    = 4'd8,
        PH_DONE     = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        EV_NUMBER    = 3'd0,
        EV_STR_BYTE  = 3'd1,
        EV_STR_START = 3'd2,
        EV_STR_CLOSE = 3'd3,
        EV_STATUS    = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ACC_W-1:0]  payload;
        logic              success;
        logic              last;
    } evt_t;

    typedef struct packed {
        logic [KEY_W-1:0] number_key;
        logic [LEN_W-1:0] number_len;
        logic [KEY_W-1:0] string_key;
        logic [LEN_W-1:0] string_len;
    } cfg_t;

endpackage

>>> sv/fje_parser.sv
// parser state and per-byte event generation
module fje_parser
    import fje_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  logic [7:0]  byte_in,
    input  logic        last_in,
    input  cfg_t        cfg,
    output evt_t        evt0,
    output evt_t        evt1,
    output logic [1:0]  push_cnt
);

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               num_cand_reg, num_cand_next;
    logic               str_cand_reg, str_cand_next;
    logic               cur_num_reg, cur_num_next;
    logic               cur_str_reg, cur_str_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               err_reg, err_next;

    logic               digit;
    logic               ws;
    logic               skip;
    phase_t             ph;
    logic [ACC_W+3:0]   acc_ext;
    logic [ACC_W+3:0]   prod;
    logic               num_v;
    logic               mid_v;
    evt_t               mid_e;
    logic               fin_v;
    evt_t               num_e;
    evt_t               fin_e;

    function automatic logic key_hit(input logic [KEY_W-1:0] key, input logic [LEN_W-1:0] len,
                                     input logic [POS_W-1:0] pos, input logic [7:0] b);
        logic [KEY_IDX_W-1:0] idx;
        idx = pos[KEY_IDX_W-1:0];
        return (pos < len) && (32'(pos) < KEY_CHARS) && (key[8*idx +: 8] == b);
    endfunction

    assign digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign ws = (byte_in == CH_SPACE) || ((byte_in >= CH_TAB) && (byte_in <= CH_CR));
    assign acc_ext = {4'b0000, acc_reg};
    // times ten plus digit; low nibble of an ascii digit is its value
    assign prod = (acc_ext << 3) + (acc_ext << 1) + {{ACC_W{1'b0}}, byte_in[3:0]};

    always_comb begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        num_cand_next = num_cand_reg;
        str_cand_next = str_cand_reg;
        cur_num_next = cur_num_reg;
        cur_str_next = cur_str_reg;
        acc_next = acc_reg;
        err_next = err_reg;
        skip = 1'b0;
        ph = phase_reg;
        num_v = 1'b0;
        mid_v = 1'b0;
        mid_e = '{kind: EV_STATUS, payload: '0, success: 1'b0, last: 1'b0};
        fin_v = 1'b0;

        if (!err_reg) begin
            if (phase_reg == PH_NUMBER) begin
                if (digit) begin
                    acc_next = (prod[ACC_W+3:ACC_W] != 4'd0) ? {ACC_W{1'b1}} : prod[ACC_W-1:0];
                    skip = 1'b1;
                end else begin
                    num_v = cur_num_reg;
                    ph = PH_COMMA;
                end
            end
            phase_next = ph;
            if (ws && (ph inside {PH_BRACE, PH_KEY_OPEN, PH_COLON, PH_VALUE, PH_COMMA,
                                  PH_DONE})) begin
                skip = 1'b1;
            end
            if (!skip) begin
                unique case (ph)
                    PH_BRACE: begin
                        if (byte_in == CH_LBRACE) begin
                            phase_next = PH_KEY_OPEN;
                        end else begin
                            err_next = 1'b1;
                            mid_v = !last_in;
                        end
                    end
                    PH_KEY_OPEN: begin
                        if (byte_in == CH_QUOTE) begin
                            pos_next = '0;
                            num_cand_next = 1'b1;
                            str_cand_next = 1'b1;
                            phase_next = PH_KEY_NAME;
                        end else begin
                            err_next = 1'b1;
                            mid_v = !last_in;
                        end
                    end
                    PH_KEY_NAME: begin
                        if (byte_in == CH_QUOTE) begin
                            cur_num_next = num_cand_reg && (pos_reg == POS_W'(cfg.number_len));
                            cur_str_next = str_cand_reg && (pos_reg == POS_W'(cfg.string_len));
                            phase_next = PH_COLON;
                        end else begin
                            if (!key_hit(cfg.number_key, cfg.number_len, pos_reg, byte_in)) begin
                                num_cand_next = 1'b0;
                            end
                            if (!key_hit(cfg.string_key, cfg.string_len, pos_reg, byte_in)) begin
                                str_cand_next = 1'b0;
                            end
                            if (pos_reg != POS_MAX) begin
                                pos_next = pos_reg + 1'b1;
                            end
                        end
                    end
                    PH_COLON: begin
                        if (byte_in == CH_COLON) begin
                            phase_next = PH_VALUE;
                        end else begin
                            err_next = 1'b1;
                            mid_v = !last_in;
                        end
                    end
                    PH_VALUE: begin
                        if (digit) begin
                            acc_next = {{(ACC_W-4){1'b0}}, byte_in[3:0]};
                            phase_next = PH_NUMBER;
                        end else if (byte_in == CH_QUOTE) begin
                            mid_v = cur_str_reg;
                            mid_e.kind = EV_STR_START;
                            phase_next = PH_STRING;
                        end
                    end
                    PH_STRING: begin
                        if (byte_in == CH_QUOTE) begin
                            mid_v = cur_str_reg;
                            mid_e.kind = EV_STR_CLOSE;
                            phase_next = PH_COMMA;
                        end else if (byte_in == CH_BSLASH) begin
                            phase_next = PH_ESCAPE;
                        end else begin
                            mid_v = cur_str_reg;
                            mid_e.kind = EV_STR_BYTE;
                            mid_e.payload = {{(ACC_W-8){1'b0}}, byte_in};
                        end
                    end
                    PH_ESCAPE: begin
                        mid_v = cur_str_reg;
                        mid_e.kind = EV_STR_BYTE;
                        mid_e.payload = {{(ACC_W-8){1'b0}}, byte_in};
                        phase_next = PH_STRING;
                    end
                    PH_COMMA: begin
                        if (byte_in == CH_COMMA) begin
                            phase_next = PH_KEY_OPEN;
                        end else if (byte_in == CH_RBRACE) begin
                            phase_next = PH_DONE;
                        end else begin
                            err_next = 1'b1;
                            mid_v = !last_in;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        fin_v = last_in;
        fin_e = '{kind: EV_STATUS, payload: '0, success: !err_next, last: 1'b1};
        num_e = '{kind: EV_NUMBER, payload: acc_reg, success: 1'b0, last: 1'b0};

        // end of document puts the parser back to its reset state
        if (last_in) begin
            phase_next = PH_BRACE;
            pos_next = '0;
            num_cand_next = 1'b1;
            str_cand_next = 1'b1;
            cur_num_next = 1'b0;
            cur_str_next = 1'b0;
            acc_next = '0;
            err_next = 1'b0;
        end
    end

    // order is number, then mid event, then final status; at most two are valid
    always_comb begin
        evt0 = fin_e;
        evt1 = fin_e;
        push_cnt = 2'd0;
        if (num_v) begin
            evt0 = num_e;
            if (mid_v) begin
                evt1 = mid_e;
                evt1.last = 1'b1;
                push_cnt = 2'd2;
            end else if (fin_v) begin
                push_cnt = 2'd2;
            end else begin
                evt0.last = 1'b1;
                push_cnt = 2'd1;
            end
        end else if (mid_v) begin
            evt0 = mid_e;
            if (fin_v) begin
                push_cnt = 2'd2;
            end else begin
                evt0.last = 1'b1;
                push_cnt = 2'd1;
            end
        end else if (fin_v) begin
            push_cnt = 2'd1;
        end
        if (!step_en) begin
            push_cnt = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_BRACE;
            pos_reg <= '0;
            num_cand_reg <= 1'b1;
            str_cand_reg <= 1'b1;
            cur_num_reg <= 1'b0;
            cur_str_reg <= 1'b0;
            acc_reg <= '0;
            err_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            num_cand_reg <= num_cand_next;
            str_cand_reg <= str_cand_next;
            cur_num_reg <= cur_num_next;
            cur_str_reg <= cur_str_next;
            acc_reg <= acc_next;
            err_reg <= err_next;
        end
    end

endmodule

>>> sv/fje_out_fifo.sv
// result queue taking up to two events per cycle and giving one while out_ready is high
module fje_out_fifo
    import fje_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  push_cnt,
    input  evt_t        evt0,
    input  evt_t        evt1,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output evt_t        out_evt
);

    evt_t                   mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                   pop;
    logic [FIFO_PTR_W-1:0]  wr_ptr_p1;

    assign pop = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_evt = mem_reg[rd_ptr_reg];
    assign room = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= evt0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_p1] <= evt1;
        end
    end

`include "flat_json_field_extractor_assert.svh"

    `FJE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
    `FJE_ASSERT_NOW(a_push_has_room, push_cnt != 2'd0, room)
    `FJE_ASSERT_NEXT(a_pop_drains, pop && (push_cnt == 2'd0),
        count_reg == $past(count_reg) - 1'b1)

endmodule

>>> sv/flat_json_field_extractor.sv
// Flat JSON field extractor. Bytes enter one per cycle on the s_ stream while
// s_tready is high and go through an input register into the parser, whose
// events land in a four-entry result queue read on the m_ stream; the queue's
// registered count drives m_tvalid. A byte that causes two results (a number
// ending together with an error or the end of the document, or a string
// event on the last byte) fills two queue entries, so sustained throughput
// is one byte per cycle while each byte yields at most one result and
// m_tready stays high, and is bounded by the one-result-per-cycle output
// port otherwise. Configuration must be written over the APB port while the
// stream is idle; the block itself does not enforce this. Registers sit at
// byte addresses 0, 8, 16 and 24.
module flat_json_field_extractor
    import fje_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // [15:0] payload, [16] success, [23:17] zero
    output logic [2:0]   m_tuser,   // [2:0] event_kind
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        advance;
    logic        room;
    logic        cfg_wr;
    logic [1:0]  reg_idx;
    cfg_t        cfg_reg;
    evt_t        evt0;
    evt_t        evt1;
    logic [1:0]  push_cnt;
    evt_t        out_evt;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.number_key <= NUMBER_KEY_RST;
            cfg_reg.number_len <= NUMBER_LEN_RST;
            cfg_reg.string_key <= STRING_KEY_RST;
            cfg_reg.string_len <= STRING_LEN_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_NUMBER_KEY: cfg_reg.number_key <= pwdata;
                REG_NUMBER_LEN: cfg_reg.number_len <= pwdata[LEN_W-1:0];
                REG_STRING_KEY: cfg_reg.string_key <= pwdata;
                REG_STRING_LEN: cfg_reg.string_len <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NUMBER_KEY: prdata = cfg_reg.number_key;
            REG_NUMBER_LEN: prdata = {60'd0, cfg_reg.number_len};
            REG_STRING_KEY: prdata = cfg_reg.string_key;
            REG_STRING_LEN: prdata = {60'd0, cfg_reg.string_len};
            default: prdata = '0;
        endcase
    end

    // the held byte moves on only when the queue can take two events
    assign advance = in_valid_reg && room;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    fje_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .byte_in  (in_byte_reg),
        .last_in  (in_last_reg),
        .cfg      (cfg_reg),
        .evt0     (evt0),
        .evt1     (evt1),
        .push_cnt (push_cnt)
    );

    fje_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .evt0      (evt0),
        .evt1      (evt1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_evt   (out_evt)
    );

    assign m_tdata = {7'd0, out_evt.success, out_evt.payload};
    assign m_tuser = out_evt.kind;
    assign m_tlast = out_evt.last;

endmodule
